// ===== sv/dpd_pkg.sv =====
package dpd_pkg;

	localparam logic [7:0] SYM_START = 8'h24;
	localparam logic [7:0] SYM_END   = 8'h23;
	localparam logic [7:0] SYM_BREAK = 8'h03;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_DATA = 2'd1,
		PH_HI   = 2'd2,
		PH_LO   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_DATA    = 3'd0,
		EV_GOOD    = 3'd1,
		EV_BAD     = 3'd2,
		EV_BREAK   = 3'd3,
		EV_RESTART = 3'd4
	} ev_kind_t;

	// One result of a deframing step, handed from the core to the output stage.
	typedef struct packed {
		logic       has_result;
		ev_kind_t   kind;
		logic [7:0] data;
	} result_t;

	// Value of an ASCII hex digit; anything else counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

// ===== sv/dpd_core.sv =====
module dpd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        rx_byte_s1,
	output dpd_pkg::result_t  res,
	output dpd_pkg::phase_t   phase
);
	import dpd_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] sum_q;
	logic [7:0] sum_d;
	logic [3:0] hi_nibble_q;
	logic [3:0] hi_nibble_d;
	logic [3:0] digit;

	assign digit = hex_value(rx_byte_s1);
	assign phase = phase_q;

	// Next-state logic for the framing phase and the checksum registers.
	always_comb begin
		phase_d     = phase_q;
		sum_d       = sum_q;
		hi_nibble_d = hi_nibble_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == SYM_START) begin
					phase_d = PH_DATA;
					sum_d   = 8'd0;
				end
			end
			PH_DATA: begin
				if (rx_byte_s1 == SYM_START) begin
					sum_d = 8'd0;
				end else if (rx_byte_s1 == SYM_END) begin
					phase_d = PH_HI;
				end else begin
					sum_d = sum_q + rx_byte_s1;
				end
			end
			PH_HI: begin
				hi_nibble_d = digit;
				phase_d     = PH_LO;
			end
			PH_LO: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// Result decode for the byte in the input register.
	always_comb begin
		res = '{has_result: 1'b0, kind: EV_DATA, data: 8'd0};
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == SYM_BREAK) begin
					res.has_result = 1'b1;
					res.kind       = EV_BREAK;
				end
			end
			PH_DATA: begin
				if (rx_byte_s1 == SYM_START) begin
					res.has_result = 1'b1;
					res.kind       = EV_RESTART;
				end else if (rx_byte_s1 != SYM_END) begin
					res.has_result = 1'b1;
					res.kind       = EV_DATA;
					res.data       = rx_byte_s1;
				end
			end
			PH_HI: begin
				res.has_result = 1'b0;
			end
			PH_LO: begin
				res.has_result = 1'b1;
				res.kind       = ({hi_nibble_q, digit} == sum_q) ? EV_GOOD : EV_BAD;
			end
			default: begin
				res.has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			sum_q       <= 8'd0;
			hi_nibble_q <= 4'd0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			sum_q       <= sum_d;
			hi_nibble_q <= hi_nibble_d;
		end
	end

endmodule

// ===== sv/dpd_out_stage.sv =====
module dpd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  dpd_pkg::result_t  res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        event_kind,
	output logic [7:0]        payload_byte
);
	import dpd_pkg::*;

	logic       valid_q;
	ev_kind_t   kind_q;
	logic [7:0] data_q;

	// The register can take a new result when empty or being emptied this cycle.
	assign space        = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign event_kind   = kind_q;
	assign payload_byte = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step_en && res.has_result) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.has_result) begin
			kind_q <= res.kind;
			data_q <= res.data;
		end
	end

endmodule

// ===== sv/debug_packet_deframer.sv =====
// Debug-link packet deframer.
// The input channel (in_valid, in_ready, rx_byte) takes one received link byte
// per item. The block hunts for '$', forwards payload bytes with a running
// modulo-256 sum, and after '#' and two hex digits reports whether the packet
// checksum is good or bad. A 0x03 byte while hunting reports a break, and a
// '$' inside a payload reports a restart so that the partial payload is dropped.
// The output channel (out_valid, out_ready, event_kind, payload_byte) carries
// at most one result item for each input item; bytes that only move the
// framing along give none.
// A result passes from the input register through the framing logic into the
// result register, which drives the output channel.
// Throughput is one byte per cycle while the receiver does not stall; the
// framing update between the input and result registers is combinational.
// When the receiver stalls, the result register holds, the byte in the input
// register waits for it, and in_ready drops once both are occupied.
// Reset clears both valid flags and puts the deframer back into hunting with
// a zero checksum.
module debug_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] payload_byte
);
	import dpd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_space;
	logic       advance;
	result_t    res;
	phase_t     phase;

	// The byte in the input register is processed as soon as the result
	// register can take whatever it produces.
	assign advance  = valid_s1 && out_space;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	dpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.rx_byte_s1 (rx_byte_s1),
		.res        (res),
		.phase      (phase)
	);

	dpd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.res          (res),
		.space        (out_space),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.payload_byte (payload_byte)
	);

	// Only payload items carry a byte.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != EV_DATA) |-> payload_byte == 8'd0)
		else $error("payload byte set on a non-payload item");

	// A checksum verdict always sends the deframer back to hunting.
	a_verdict_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.has_result && (res.kind == EV_GOOD || res.kind == EV_BAD)
		|=> phase == PH_HUNT)
		else $error("checksum verdict without return to hunting");

	// A held byte in the input register stays put while the output is blocked.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input register changed during output stall");

	// Break is only reported from the hunting phase.
	a_break_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.has_result && res.kind == EV_BREAK |-> phase == PH_HUNT)
		else $error("break reported outside hunting");

endmodule
